FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk with synchronous rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check outside reset
`define ASSERT_PROP(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// check on every edge, reset included
`define ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: rtl/fspa_pkg.sv
// ----------------------------------------------------------------------------
// Frame sync phase ambiguity package
// Sizes, register codes, shared types and the sync reference builder.
// ----------------------------------------------------------------------------
package fspa_pkg;

  localparam int MAX_SYNC_BITS     = 64;
  localparam int FRAME_COUNT_WIDTH = 16;
  localparam int CELL_BITS         = 8;
  localparam int NUM_CELLS         = MAX_SYNC_BITS / CELL_BITS;
  localparam int NUM_PATS          = 4;
  localparam int CNT_W             = $clog2(CELL_BITS + 1);
  localparam int DIST_W            = $clog2(MAX_SYNC_BITS + 1);
  localparam int BSS_W             = FRAME_COUNT_WIDTH + 1;
  localparam int LEN_W             = 7;
  localparam int RUN_W             = 8;
  localparam int BYTE_W            = 8;
  localparam int PHASE_W           = 2;
  localparam int PATTERN_W         = 64;
  localparam int CFG_IDX_W         = 3;
  localparam int CFG_DATA_W        = 64;
  localparam int PIPE_DEPTH        = 3;
  localparam int PEND_W            = $clog2(PIPE_DEPTH + 2);

  localparam logic [PATTERN_W-1:0]         RST_SYNC_PATTERN   = 64'd449838109;
  localparam logic [LEN_W-1:0]             RST_SYNC_LENGTH    = 7'd32;
  localparam logic [RUN_W-1:0]             RST_SEARCH_TO_LOCK = 8'd2;
  localparam logic [RUN_W-1:0]             RST_LOCK_TO_SEARCH = 8'd2;
  localparam logic [LEN_W-1:0]             RST_LOCK_TOLERANCE = 7'd3;
  localparam logic [FRAME_COUNT_WIDTH-1:0] RST_FRAME_BITS     = 16'd8192;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SYNC_PATTERN,
    REG_SYNC_LENGTH,
    REG_SEARCH_TO_LOCK,
    REG_LOCK_TO_SEARCH,
    REG_LOCK_TOLERANCE,
    REG_FRAME_BITS
  } cfg_reg_t;

  typedef enum logic {
    ST_SEARCH,
    ST_LOCK
  } sync_state_t;

  typedef logic [NUM_PATS-1:0][MAX_SYNC_BITS-1:0] pat_set_t;

  typedef struct packed {
    logic [MAX_SYNC_BITS-1:0] mask;
    pat_set_t                 pat;
  } ref_set_t;

  typedef struct packed {
    logic [CELL_BITS-1:0]                mask;
    logic [NUM_PATS-1:0][CELL_BITS-1:0]  pat;
  } cell_ref_t;

  typedef logic [NUM_PATS-1:0][CNT_W-1:0]                 cell_cnt_t;
  typedef logic [NUM_CELLS-1:0][NUM_PATS-1:0][CNT_W-1:0]  part_set_t;
  typedef logic [NUM_PATS-1:0][DIST_W-1:0]                dist_set_t;

  typedef struct packed {
    logic [LEN_W-1:0]             lock_tolerance;
    logic [RUN_W-1:0]             search_to_lock;
    logic [RUN_W-1:0]             lock_to_search;
    logic [FRAME_COUNT_WIDTH-1:0] frame_bits;
  } ctrl_cfg_t;

  // 0, 90, 180 and 270 degree references plus the length mask
  function automatic ref_set_t build_refs(logic [PATTERN_W-1:0] sp, logic [LEN_W-1:0] len_raw);
    logic [LEN_W-1:0] len;
    logic             s;
    logic             i_even;
    ref_set_t         r;
    len = (len_raw > LEN_W'(MAX_SYNC_BITS)) ? LEN_W'(MAX_SYNC_BITS) : len_raw;
    for (int b = 0; b < MAX_SYNC_BITS; b++) begin
      r.mask[b] = (LEN_W'(b) < len);
      i_even    = (1'(b) != len[0]);
      s         = 1'b0;
      if (i_even) begin
        if (b > 0) s = sp[b-1];
      end else begin
        if (b < MAX_SYNC_BITS - 1) s = sp[b+1];
      end
      r.pat[0][b] = sp[b] & r.mask[b];
      r.pat[1][b] = (s ^ i_even) & r.mask[b];
      r.pat[2][b] = ~sp[b] & r.mask[b];
      r.pat[3][b] = (s ^ ~i_even) & r.mask[b];
    end
    return r;
  endfunction

endpackage

FILE: rtl/fspa_ifs.sv
// ----------------------------------------------------------------------------
// Frame sync phase ambiguity channels
// Valid/ready channels for input bytes, tagged results and register writes.
// ----------------------------------------------------------------------------
interface fspa_in_if import fspa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source(output valid, output rx_byte, input ready);
  modport sink(input valid, input rx_byte, output ready);
endinterface

interface fspa_out_if import fspa_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [BYTE_W-1:0]  data_out;
  logic               tag_valid;
  logic [PHASE_W-1:0] phase_code;
  logic               locked;

  modport source(output valid, output data_out, output tag_valid, output phase_code,
                 output locked, input ready);
  modport sink(input valid, input data_out, input tag_valid, input phase_code,
               input locked, output ready);
endinterface

interface fspa_cfg_if import fspa_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

FILE: rtl/fspa_cell.sv
// ----------------------------------------------------------------------------
// Window cell
// Holds one slice of the bit window, shifts it toward the next cell and
// registers the slice's mismatch counts against the four references.
// ----------------------------------------------------------------------------
module fspa_cell import fspa_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      shift,
  input  logic      carry_in,
  input  cell_ref_t refs,
  output logic      carry_out,
  output cell_cnt_t counts
);

  logic [CELL_BITS-1:0] bits;
  cell_cnt_t            counts_next;

  always_comb begin
    for (int k = 0; k < NUM_PATS; k++) begin
      counts_next[k] = '0;
      for (int b = 0; b < CELL_BITS; b++) begin
        counts_next[k] = counts_next[k] +
                         CNT_W'((bits[b] ^ refs.pat[k][b]) & refs.mask[b]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bits <= '0;
    end else if (shift) begin
      bits <= {bits[CELL_BITS-2:0], carry_in};
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      counts <= counts_next;
    end
  end

  assign carry_out = bits[CELL_BITS-1];

endmodule

FILE: rtl/fspa_ctrl.sv
// ----------------------------------------------------------------------------
// Sync control
// Sums cell counts into distances, then runs match, run counters, lock
// state and frame tagging into the output register.
// ----------------------------------------------------------------------------
module fspa_ctrl import fspa_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              s1_valid,
  output logic              s1_ready,
  input  logic [BYTE_W-1:0] s1_byte,
  input  part_set_t         parts,
  input  ctrl_cfg_t         ccfg,
  fspa_out_if.source        tx
);

  localparam logic [BSS_W-1:0] BSS_MAX = '1;
  localparam logic [RUN_W-1:0] RUN_MAX = '1;

  logic              s2_valid;
  logic              s2_ready;
  logic              s3_ready;
  logic [BYTE_W-1:0] s2_byte;
  dist_set_t         s2_dist;
  dist_set_t         dist_sum;
  logic              step;

  sync_state_t                  state, state_next;
  logic [LEN_W-1:0]             thr, thr_next;
  logic [PHASE_W-1:0]           phase, phase_next;
  logic [RUN_W-1:0]             good_run, good_next;
  logic [RUN_W-1:0]             bad_run, bad_next;
  logic [BSS_W-1:0]             bss, bss_mid, bss_next;
  logic [FRAME_COUNT_WIDTH-1:0] fp, fp_mid, fp_next;
  logic [FRAME_COUNT_WIDTH:0]   fp_inc;
  logic [FRAME_COUNT_WIDTH-1:0] fb_eff;
  logic [DIST_W-1:0]            best;
  logic [PHASE_W-1:0]           best_idx;
  logic                         sync_hit;
  logic                         good_gap;
  logic                         tag;

  always_comb begin
    for (int k = 0; k < NUM_PATS; k++) begin
      dist_sum[k] = '0;
      for (int c = 0; c < NUM_CELLS; c++) begin
        dist_sum[k] = dist_sum[k] + DIST_W'(parts[c][k]);
      end
    end
  end

  assign s3_ready = !tx.valid || tx.ready;
  assign s2_ready = !s2_valid || s3_ready;
  assign s1_ready = s2_ready;
  assign step     = s2_valid && s3_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s2_ready) begin
      s2_byte <= s1_byte;
      s2_dist <= dist_sum;
    end
  end

  // first minimum wins on ties
  always_comb begin
    best     = s2_dist[0];
    best_idx = '0;
    for (int k = 1; k < NUM_PATS; k++) begin
      if (s2_dist[k] < best) begin
        best     = s2_dist[k];
        best_idx = PHASE_W'(k);
      end
    end
  end

  assign fb_eff   = (ccfg.frame_bits == '0) ? FRAME_COUNT_WIDTH'(1) : ccfg.frame_bits;
  assign good_gap = (bss >= {1'b0, fb_eff}) && (bss < {fb_eff, 1'b0});
  assign sync_hit = ({1'b0, best} <= {{(LEN_W + 1 - DIST_W){1'b0}}, thr});

  // next state
  always_comb begin
    state_next = state;
    phase_next = phase;
    good_next  = good_run;
    bad_next   = bad_run;
    bss_mid    = bss;
    fp_mid     = fp;
    if (sync_hit) begin
      phase_next = best_idx;
      if (good_gap) begin
        good_next = (good_run == RUN_MAX) ? good_run : good_run + RUN_W'(1);
        bad_next  = '0;
      end else begin
        good_next = '0;
        bad_next  = (bad_run == RUN_MAX) ? bad_run : bad_run + RUN_W'(1);
      end
      if (state == ST_SEARCH && good_next >= ccfg.search_to_lock) begin
        state_next = ST_LOCK;
      end
      if (state_next == ST_LOCK && bad_next >= ccfg.lock_to_search) begin
        state_next = ST_SEARCH;
      end
      bss_mid = '0;
      fp_mid  = '0;
    end
    bss_next = (bss_mid == BSS_MAX) ? bss_mid : bss_mid + BSS_W'(1);
    fp_inc   = {1'b0, fp_mid} + (FRAME_COUNT_WIDTH + 1)'(1);
    fp_next  = (fp_inc >= {1'b0, fb_eff}) ? '0 : fp_inc[FRAME_COUNT_WIDTH-1:0];
  end

  // outputs
  always_comb begin
    thr_next = '0;
    tag      = 1'b0;
    if (state_next == ST_LOCK) begin
      thr_next = ccfg.lock_tolerance;
      tag      = (fp_mid == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_SEARCH;
      thr      <= '0;
      phase    <= '0;
      good_run <= '0;
      bad_run  <= '0;
      bss      <= '0;
      fp       <= '0;
      tx.valid <= 1'b0;
    end else begin
      if (s3_ready) begin
        tx.valid <= s2_valid;
      end
      if (step) begin
        state    <= state_next;
        thr      <= thr_next;
        phase    <= phase_next;
        good_run <= good_next;
        bad_run  <= bad_next;
        bss      <= bss_next;
        fp       <= fp_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      tx.data_out   <= s2_byte;
      tx.tag_valid  <= tag;
      tx.phase_code <= phase_next;
      tx.locked     <= (state_next == ST_LOCK);
    end
  end

endmodule

FILE: rtl/frame_sync_phase_ambiguity_unit.sv
// A result beat passes the s1, s2 and tx registers once its input is accepted.
// Throughput: one beat per cycle unless tx stalls, set by the control stage's
// lock and run counter update. Window cells correlate in one registered stage.
// Reset: rst clears the window, sync state and pipeline and loads the register
// defaults; no clearing pass, the first beat is taken right after reset.
// ----------------------------------------------------------------------------
// Frame sync phase ambiguity unit
// Hard-bit frame synchronizer with 0/90/180/270 degree sync word detection,
// search/lock tracking and frame boundary tags on a pass-through byte stream.
// ----------------------------------------------------------------------------
module frame_sync_phase_ambiguity_unit import fspa_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  fspa_in_if.sink    rx,
  fspa_out_if.source tx,
  fspa_cfg_if.sink   cfg
);

  logic [PATTERN_W-1:0]         sync_pattern;
  logic [LEN_W-1:0]             sync_length;
  logic [RUN_W-1:0]             search_to_lock;
  logic [RUN_W-1:0]             lock_to_search;
  logic [LEN_W-1:0]             lock_tolerance;
  logic [FRAME_COUNT_WIDTH-1:0] frame_bits;

  ref_set_t          refs;
  cell_ref_t         cell_refs [NUM_CELLS];
  logic              carry [NUM_CELLS+1];
  part_set_t         parts;
  ctrl_cfg_t         ccfg;
  logic              shift;
  logic              s1_valid;
  logic              s1_ready;
  logic [BYTE_W-1:0] s1_byte;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_pattern   <= RST_SYNC_PATTERN;
      sync_length    <= RST_SYNC_LENGTH;
      search_to_lock <= RST_SEARCH_TO_LOCK;
      lock_to_search <= RST_LOCK_TO_SEARCH;
      lock_tolerance <= RST_LOCK_TOLERANCE;
      frame_bits     <= RST_FRAME_BITS;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg_reg_t'(cfg.index))
        REG_SYNC_PATTERN:   sync_pattern   <= cfg.data[PATTERN_W-1:0];
        REG_SYNC_LENGTH:    sync_length    <= cfg.data[LEN_W-1:0];
        REG_SEARCH_TO_LOCK: search_to_lock <= cfg.data[RUN_W-1:0];
        REG_LOCK_TO_SEARCH: lock_to_search <= cfg.data[RUN_W-1:0];
        REG_LOCK_TOLERANCE: lock_tolerance <= cfg.data[LEN_W-1:0];
        REG_FRAME_BITS:     frame_bits     <= cfg.data[FRAME_COUNT_WIDTH-1:0];
        default: begin
        end
      endcase
    end
  end

  assign refs = build_refs(sync_pattern, sync_length);

  assign ccfg.lock_tolerance = lock_tolerance;
  assign ccfg.search_to_lock = search_to_lock;
  assign ccfg.lock_to_search = lock_to_search;
  assign ccfg.frame_bits     = frame_bits;

  assign rx.ready = !s1_valid || s1_ready;
  assign shift    = rx.valid && rx.ready;
  assign carry[0] = rx.rx_byte[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (rx.ready) begin
      s1_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      s1_byte <= rx.rx_byte;
    end
  end

  for (genvar c = 0; c < NUM_CELLS; c++) begin : g_cell
    assign cell_refs[c].mask = refs.mask[c*CELL_BITS +: CELL_BITS];
    for (genvar k = 0; k < NUM_PATS; k++) begin : g_pat
      assign cell_refs[c].pat[k] = refs.pat[k][c*CELL_BITS +: CELL_BITS];
    end

    fspa_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .shift     (shift),
      .carry_in  (carry[c]),
      .refs      (cell_refs[c]),
      .carry_out (carry[c+1]),
      .counts    (parts[c])
    );
  end

  fspa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s1_valid (s1_valid),
    .s1_ready (s1_ready),
    .s1_byte  (s1_byte),
    .parts    (parts),
    .ccfg     (ccfg),
    .tx       (tx)
  );

endmodule

FILE: rtl/fspa_checker.sv
// ----------------------------------------------------------------------------
// Frame sync phase ambiguity checker
// Port-level checks on result holding, pipeline occupancy and tag/lock outputs.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fspa_checker import fspa_pkg::*; (
  input logic clk,
  input logic rst,
  input logic rx_valid,
  input logic rx_ready,
  input logic tx_valid,
  input logic tx_ready,
  input logic tx_tag_valid,
  input logic tx_locked
);

  logic [PEND_W-1:0] pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + PEND_W'(rx_valid && rx_ready) - PEND_W'(tx_valid && tx_ready);
    end
  end

  `ASSERT_PROP(a_tag_only_locked, tx_valid && tx_tag_valid |-> tx_locked, "tag while in search")
  `ASSERT_PROP(a_out_hold, tx_valid && !tx_ready |=> tx_valid, "result beat dropped")
  `ASSERT_PROP(a_depth, pending <= PEND_W'(PIPE_DEPTH), "more beats in flight than stages")
  `ASSERT_PROP(a_no_orphan, tx_valid |-> pending != '0, "result without an input beat")
  `ASSERT_ALWAYS(a_reset_idle, rst |=> !tx_valid, "result valid after reset")

endmodule

bind frame_sync_phase_ambiguity_unit fspa_checker u_fspa_checker (
  .clk          (clk),
  .rst          (rst),
  .rx_valid     (rx.valid),
  .rx_ready     (rx.ready),
  .tx_valid     (tx.valid),
  .tx_ready     (tx.ready),
  .tx_tag_valid (tx.tag_valid),
  .tx_locked    (tx.locked)
);

FILE: verif/frame_sync_phase_ambiguity_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame sync phase ambiguity monitor
// Watches the register, input and result channels, keeps its own copy of the
// sync search/lock state, predicts every result beat and compares it field by
// field in arrival order. Hands the mismatch count and open beats to the top.
// ----------------------------------------------------------------------------
module frame_sync_phase_ambiguity_monitor import fspa_pkg::*; (
  input  logic clk,
  input  logic rst,
  fspa_in_if   rx,
  fspa_out_if  tx,
  fspa_cfg_if  cfg,
  output int   mismatch_count,
  output int   outstanding
);

  typedef struct packed {
    logic [BYTE_W-1:0]  data;
    logic               tag;
    logic [PHASE_W-1:0] phase;
    logic               locked;
  } sync_result_t;

  sync_result_t expected_q[$];

  logic [PATTERN_W-1:0]         word_reg;
  logic [LEN_W-1:0]             word_len;
  logic [RUN_W-1:0]             lock_need;
  logic [RUN_W-1:0]             drop_need;
  logic [LEN_W-1:0]             lock_tol;
  logic [FRAME_COUNT_WIDTH-1:0] frame_len;

  logic [MAX_SYNC_BITS-1:0]     window;
  sync_state_t                  sync_state;
  logic [LEN_W-1:0]             match_limit;
  logic [PHASE_W-1:0]           last_phase;
  logic [RUN_W-1:0]             good_streak;
  logic [RUN_W-1:0]             bad_streak;
  logic [BSS_W-1:0]             since_sync;
  logic [BSS_W-1:0]             frame_pos;

  initial begin
    mismatch_count = 0;
    outstanding    = 0;
  end

  task report_mismatch(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("%0t mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    mismatch_count++;
  endtask

  task reset_model();
    word_reg    = RST_SYNC_PATTERN;
    word_len    = RST_SYNC_LENGTH;
    lock_need   = RST_SEARCH_TO_LOCK;
    drop_need   = RST_LOCK_TO_SEARCH;
    lock_tol    = RST_LOCK_TOLERANCE;
    frame_len   = RST_FRAME_BITS;
    window      = '0;
    sync_state  = ST_SEARCH;
    match_limit = '0;
    last_phase  = '0;
    good_streak = '0;
    bad_streak  = '0;
    since_sync  = '0;
    frame_pos   = '0;
    expected_q.delete();
  endtask

  task apply_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    case (cfg_reg_t'(idx))
      REG_SYNC_PATTERN:   word_reg  = val;
      REG_SYNC_LENGTH:    word_len  = val[LEN_W-1:0];
      REG_SEARCH_TO_LOCK: lock_need = val[RUN_W-1:0];
      REG_LOCK_TO_SEARCH: drop_need = val[RUN_W-1:0];
      REG_LOCK_TOLERANCE: lock_tol  = val[LEN_W-1:0];
      REG_FRAME_BITS:     frame_len = val[FRAME_COUNT_WIDTH-1:0];
      default: ;
    endcase
  endtask

  task predict_beat(input logic [BYTE_W-1:0] rx_b);
    int                   n;
    int                   i;
    int                   k;
    int                   partner;
    int                   best;
    int                   hd [NUM_PATS];
    logic                 s;
    logic                 tag;
    logic [PATTERN_W-1:0] m;
    logic [PATTERN_W-1:0] refs [NUM_PATS];
    logic [BSS_W:0]       fb;
    n = (word_len > LEN_W'(MAX_SYNC_BITS)) ? MAX_SYNC_BITS : int'(word_len);
    m = (n == 0) ? '0 : ({PATTERN_W{1'b1}} >> (PATTERN_W - n));
    refs[0] = word_reg & m;
    refs[1] = '0;
    refs[2] = ~word_reg & m;
    refs[3] = '0;
    for (i = 0; i < n; i++) begin
      partner = i ^ 1;
      s = (partner < n) ? word_reg[n-1-partner] : 1'b0;
      refs[1][n-1-i] = s ^ (i % 2 == 0);
      refs[3][n-1-i] = s ^ (i % 2 == 1);
    end
    best = MAX_SYNC_BITS + 1;
    for (k = 0; k < NUM_PATS; k++) begin
      hd[k] = $countones((window ^ refs[k]) & m);
      if (hd[k] < best) best = hd[k];
    end

    window = {window[MAX_SYNC_BITS-2:0], rx_b[0]};
    fb = (frame_len == 0) ? (BSS_W+1)'(1) : (BSS_W+1)'(frame_len);
    tag = 1'b0;

    if (best <= int'(match_limit)) begin
      k = 0;
      while (hd[k] != best) k++;
      last_phase = PHASE_W'(k);
      if ((BSS_W+1)'(since_sync) >= fb && (BSS_W+1)'(since_sync) < 2 * fb) begin
        if (good_streak != '1) good_streak++;
        bad_streak = '0;
      end else begin
        good_streak = '0;
        if (bad_streak != '1) bad_streak++;
      end
      if (sync_state == ST_SEARCH && good_streak >= lock_need) sync_state = ST_LOCK;
      if (sync_state == ST_LOCK && bad_streak >= drop_need) sync_state = ST_SEARCH;
      since_sync = '0;
      frame_pos  = '0;
    end

    if (sync_state == ST_LOCK) begin
      match_limit = lock_tol;
      tag = (frame_pos == 0);
    end else begin
      match_limit = '0;
    end

    if (since_sync != '1) since_sync++;
    frame_pos++;
    if ((BSS_W+1)'(frame_pos) >= fb) frame_pos = '0;

    expected_q.push_back('{rx_b, tag, last_phase, sync_state == ST_LOCK});
  endtask

  task compare_beat();
    sync_result_t want;
    if (expected_q.size() == 0) begin
      report_mismatch("result beat with none pending", 64'(tx.data_out), '0);
      return;
    end
    want = expected_q.pop_front();
    if (tx.data_out !== want.data)
      report_mismatch("data_out", 64'(tx.data_out), 64'(want.data));
    if (tx.tag_valid !== want.tag)
      report_mismatch("tag_valid", 64'(tx.tag_valid), 64'(want.tag));
    if (tx.phase_code !== want.phase)
      report_mismatch("phase_code", 64'(tx.phase_code), 64'(want.phase));
    if (tx.locked !== want.locked)
      report_mismatch("locked", 64'(tx.locked), 64'(want.locked));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      reset_model();
    end else begin
      if (cfg.valid && cfg.ready) apply_write(cfg.index, cfg.data);
      if (rx.valid && rx.ready) predict_beat(rx.rx_byte);
      if (tx.valid && tx.ready) compare_beat();
    end
    outstanding = expected_q.size();
  end

endmodule

FILE: verif/frame_sync_phase_ambiguity_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame sync phase ambiguity unit testbench
// Drives byte streams carrying the sync word in all four rotations, with bit
// errors, bad spacing and noise, under a series of register settings that
// include the extremes. Random stalls on both channels; the monitor predicts
// and checks every result beat.
// ----------------------------------------------------------------------------
module frame_sync_phase_ambiguity_unit_tb;
  import fspa_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  typedef enum int {
    PH_0,
    PH_90,
    PH_180,
    PH_270
  } ambiguity_t;

  logic clk;
  logic rst;
  int   mismatches;
  int   outstanding;
  int   sent_count   = 0;
  int   src_idle_pct = 0;
  int   snk_idle_pct = 0;
  bit   hold_done    = 1'b0;
  int   cycle_count  = 0;

  fspa_in_if  rx_ch();
  fspa_out_if tx_ch();
  fspa_cfg_if cfg_ch();

  frame_sync_phase_ambiguity_unit dut (
    .clk,
    .rst,
    .rx(rx_ch),
    .tx(tx_ch),
    .cfg(cfg_ch)
  );

  frame_sync_phase_ambiguity_monitor sync_monitor (
    .clk,
    .rst,
    .rx(rx_ch),
    .tx(tx_ch),
    .cfg(cfg_ch),
    .mismatch_count(mismatches),
    .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("status: fail");
    $finish;
  end

  // hold off once for a long stretch while the sender keeps offering
  initial begin
    int hold_left;
    hold_left = 0;
    tx_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left == 0 && !hold_done && sent_count >= 150) begin
        hold_done = 1'b1;
        hold_left = 80;
      end
      if (hold_left > 0) begin
        hold_left--;
        tx_ch.ready <= 1'b0;
      end else begin
        tx_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  function automatic logic word_bit(logic [PATTERN_W-1:0] pat, int n, int i, ambiguity_t ph);
    int   partner;
    logic s;
    partner = i ^ 1;
    s = (partner < n) ? pat[n-1-partner] : 1'b0;
    case (ph)
      PH_0:    return pat[n-1-i];
      PH_90:   return s ^ (i % 2 == 0);
      PH_180:  return ~pat[n-1-i];
      default: return s ^ (i % 2 == 1);
    endcase
  endfunction

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    if (sent_count < 200) begin
      src_idle_pct = 36;
      snk_idle_pct = 79;
    end else if (sent_count < 400) begin
      src_idle_pct = 79;
      snk_idle_pct = 36;
    end else begin
      src_idle_pct = 0;
      snk_idle_pct = 0;
    end
    while ($urandom_range(99) < src_idle_pct) begin
      rx_ch.valid <= 1'b0;
      @(negedge clk);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    @(posedge clk);
    while (!rx_ch.ready) @(posedge clk);
    sent_count++;
    @(negedge clk);
  endtask

  task automatic send_stream_bit(input logic b);
    send_byte({7'($urandom), b});
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic configure(input logic [PATTERN_W-1:0] pat, input int len, input int lock_need,
                           input int drop_need, input int tol, input int frame);
    rx_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    write_reg(REG_SYNC_PATTERN, pat);
    write_reg(REG_SYNC_LENGTH, CFG_DATA_W'(len));
    write_reg(REG_SEARCH_TO_LOCK, CFG_DATA_W'(lock_need));
    write_reg(REG_LOCK_TO_SEARCH, CFG_DATA_W'(drop_need));
    write_reg(REG_LOCK_TOLERANCE, CFG_DATA_W'(tol));
    write_reg(REG_FRAME_BITS, CFG_DATA_W'(frame));
    cfg_ch.valid <= 1'b0;
  endtask

  // sync word in a rotation that changes now and then, payload, odd spacing and noise
  task automatic send_frames(input logic [PATTERN_W-1:0] pat, input int len, input int spacing,
                             input int err_div, input int count);
    int         n;
    int         i;
    int         gap;
    int         sent;
    logic       b;
    ambiguity_t ph;
    n = (len > MAX_SYNC_BITS) ? MAX_SYNC_BITS : len;
    sent = 0;
    ph = ambiguity_t'($urandom_range(3));
    while (sent < count) begin
      if ($urandom_range(9) == 0) ph = ambiguity_t'($urandom_range(3));
      if ($urandom_range(19) == 0) begin
        for (i = 0; i < spacing; i++) send_byte(8'($urandom));
        sent += spacing;
      end else begin
        for (i = 0; i < n; i++) begin
          b = word_bit(pat, n, i, ph);
          if (err_div != 0 && $urandom_range(err_div - 1) == 0) b = ~b;
          send_stream_bit(b);
        end
        gap = spacing - n;
        if ($urandom_range(9) == 0) gap = gap + int'($urandom_range(6)) - 3;
        if (gap < 0) gap = 0;
        for (i = 0; i < gap; i++) send_byte(8'($urandom));
        sent += n + gap;
      end
    end
  endtask

  initial begin
    logic [PATTERN_W-1:0] w;
    int                   p;
    int                   i;
    rst            = 1'b1;
    rx_ch.valid    = 1'b0;
    rx_ch.rx_byte  = '0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.index   = REG_SYNC_PATTERN;
    cfg_ch.data    = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    w = 64'hA5;
    configure(w, 4, 1, 3, 1, 4);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h01);
    send_byte(8'hFE);
    for (p = PH_0; p <= PH_270; p++) begin
      for (i = 0; i < 4; i++) send_stream_bit(word_bit(w, 4, i, ambiguity_t'(p)));
    end

    w = {$urandom, $urandom};
    configure(w, 8, 2, 2, 1, 12);
    send_frames(w, 8, 12, 50, 50);

    configure('0, 7, 1, 3, 0, 10);
    send_frames('0, 7, 10, 50, 30);

    configure('1, 64, 0, 255, 64, 70);
    send_frames('1, 64, 70, 0, 140);

    w = {$urandom, $urandom};
    configure(w, 127, 3, 1, 127, 65535);
    send_frames(w, 127, 70, 40, 40);

    w = {$urandom, $urandom};
    configure(w, 2, 2, 2, 1, 4);
    send_frames(w, 2, 4, 30, 30);

    w = {$urandom, $urandom};
    configure(w, 1, 1, 1, 0, 3);
    send_frames(w, 1, 3, 30, 20);

    w = {$urandom, $urandom};
    configure(w, 0, 255, 255, 0, 0);
    send_frames(w, 0, 8, 0, 100);

    w = {$urandom, $urandom};
    configure(w, 32, 2, 0, 3, 40);
    send_frames(w, 32, 40, 40, 40);

    configure(RST_SYNC_PATTERN, 32, 2, 2, 3, 36);
    send_frames(RST_SYNC_PATTERN, 32, 36, 40, 108);

    rx_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
